@@ hw/rtl/bwtr_pkg.sv @@
// ----------------------------------------------------------------------------
// bwtr_pkg
// Shared types, constants and the byte collation for the BWT + RLE block.
// ----------------------------------------------------------------------------
package bwtr_pkg;

  localparam int unsigned SYM_W   = 8;
  localparam int unsigned KEY_W   = 9;
  localparam int unsigned RUN_W   = 7;
  localparam int unsigned ALPHA_N = 73;
  localparam logic [RUN_W-1:0] RUN_MAX = 7'd127;

  typedef logic [SYM_W-1:0] sym_t;
  typedef logic [KEY_W-1:0] key_t;
  typedef logic [RUN_W-1:0] run_len_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load_wr;
    logic a_clr;
    logic b_init;
    logic step_init;
    logic step_adv;
    logic rank_inc;
    logic b_adv;
    logic ord_wr;
    logic a_adv;
    logic em_init;
    logic em_addr;
    logic run_start;
    logic run_inc;
    logic out_load;
    logic out_final;
    logic i_adv;
    logic blk_done;
  } bwtr_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    logic close;
    logic key_ne;
    logic key_lt;
    logic k_last;
    logic b_eq_a;
    logic b_lt_a;
    logic b_last;
    logic a_last;
    logic i_zero;
    logic i_last;
    logic sym_eq;
    logic len_max;
    logic out_busy;
  } bwtr_sts_t;

  // Collation rank: position in the fixed alphabet, else ALPHA_N + byte value
  function automatic key_t rank_of(sym_t b);
    key_t r;
    r = key_t'(ALPHA_N) + key_t'(b);
    case (b)
      8'hA1: r = 9'd0;
      8'hBF: r = 9'd1;
      8'h21: r = 9'd2;
      8'h24: r = 9'd3;
      8'h27: r = 9'd4;
      8'h2B: r = 9'd5;
      8'h2C: r = 9'd6;
      8'h2E: r = 9'd7;
      8'h2D: r = 9'd8;
      8'h3A: r = 9'd9;
      8'h3B: r = 9'd10;
      8'h3F: r = 9'd11;
      8'h5E: r = 9'd12;
      8'h5F: r = 9'd13;
      8'h7C: r = 9'd14;
      8'h5B: r = 9'd15;
      8'h5D: r = 9'd16;
      8'h28: r = 9'd17;
      8'h29: r = 9'd18;
      8'hD1: r = 9'd33;
      8'hF1: r = 9'd60;
      default: begin
        if (b >= 8'h41 && b <= 8'h4E) r = key_t'(b - 8'h41) + 9'd19;
        else if (b >= 8'h4F && b <= 8'h5A) r = key_t'(b - 8'h4F) + 9'd34;
        else if (b >= 8'h61 && b <= 8'h6E) r = key_t'(b - 8'h61) + 9'd46;
        else if (b >= 8'h6F && b <= 8'h7A) r = key_t'(b - 8'h6F) + 9'd61;
      end
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/bwtr_if.sv @@
// ----------------------------------------------------------------------------
// bwtr_if
// Valid/ready channels: input symbols and output runs.
// ----------------------------------------------------------------------------
interface bwtr_sym_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       block_end;
  modport source (output valid, output symbol, output block_end, input ready);
  modport sink   (input valid, input symbol, input block_end, output ready);
endinterface

interface bwtr_run_if;
  logic       valid;
  logic       ready;
  logic [7:0] run_symbol;
  logic [6:0] run_length;
  logic       run_final;
  modport source (output valid, output run_symbol, output run_length, output run_final,
                  input ready);
  modport sink   (input valid, input run_symbol, input run_length, input run_final,
                  output ready);
endinterface

@@ hw/rtl/bwt_then_run_length_encode.sv @@
// ----------------------------------------------------------------------------
// bwt_then_run_length_encode
// Burrows-Wheeler transform of a byte block followed by run-length coding.
// ----------------------------------------------------------------------------
// Usage: symbols arrive on "text", one byte per word. A word with block_end
// set, or the word that fills BLOCK_LEN entries, closes the block; the block
// then stops taking input until its last run is in the output register.
// Each sorted rotation gets its rank by comparing it with every other
// rotation, one byte pair at a time through the two read ports of the
// symbol store. Loading takes one symbol per cycle while text.valid is set.
// Runs leave on "runs" as (run_symbol, run_length, run_final) words held in
// an output register; a stalled receiver only pauses the emission, nothing
// is lost. Reset empties the block and drops any pending run; the stores
// need no clearing.
// ----------------------------------------------------------------------------
module bwt_then_run_length_encode #(
  parameter int unsigned BLOCK_LEN = 64
) (
  input logic         clk,
  input logic         rst,
  bwtr_sym_if.sink    text,
  bwtr_run_if.source  runs
);
  import bwtr_pkg::*;

  bwtr_cmd_t cmd;
  bwtr_sts_t sts;

  bwtr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (text.valid),
    .in_ready (text.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bwtr_dp #(.BLOCK_LEN(BLOCK_LEN)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .symbol     (text.symbol),
    .block_end  (text.block_end),
    .out_valid  (runs.valid),
    .out_ready  (runs.ready),
    .run_symbol (runs.run_symbol),
    .run_length (runs.run_length),
    .run_final  (runs.run_final),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

@@ hw/rtl/bwtr_ctrl.sv @@
// ----------------------------------------------------------------------------
// bwtr_ctrl
// Sequencer: load, rank-count sort of rotations, run-length emission.
// ----------------------------------------------------------------------------
module bwtr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bwtr_pkg::bwtr_sts_t sts,
  output bwtr_pkg::bwtr_cmd_t cmd
);
  import bwtr_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD, S_B_INIT, S_PAIR, S_RD, S_EV, S_B_NEXT, S_ORD,
    S_E_INIT, S_E_ORD, S_E_SYM, S_E_CHK, S_E_NEXT, S_E_LAST
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else     state <= state_next;
  end

  // command decode and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    unique case (state)
      S_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_wr = 1'b1;
          if (sts.close) begin
            cmd.a_clr  = 1'b1;
            state_next = S_B_INIT;
          end
        end
      end
      S_B_INIT: begin
        cmd.b_init = 1'b1;
        state_next = S_PAIR;
      end
      S_PAIR: begin
        if (sts.b_eq_a) state_next = S_B_NEXT;
        else begin
          cmd.step_init = 1'b1;
          state_next    = S_RD;
        end
      end
      S_RD: state_next = S_EV;
      S_EV: begin
        if (sts.key_ne) begin
          cmd.rank_inc = sts.key_lt;
          state_next   = S_B_NEXT;
        end else if (sts.k_last) begin
          cmd.rank_inc = sts.b_lt_a;
          state_next   = S_B_NEXT;
        end else begin
          cmd.step_adv = 1'b1;
          state_next   = S_RD;
        end
      end
      S_B_NEXT: begin
        if (sts.b_last) state_next = S_ORD;
        else begin
          cmd.b_adv  = 1'b1;
          state_next = S_PAIR;
        end
      end
      S_ORD: begin
        cmd.ord_wr = 1'b1;
        if (sts.a_last) state_next = S_E_INIT;
        else begin
          cmd.a_adv  = 1'b1;
          state_next = S_B_INIT;
        end
      end
      S_E_INIT: begin
        cmd.em_init = 1'b1;
        state_next  = S_E_ORD;
      end
      S_E_ORD: state_next = S_E_SYM;
      S_E_SYM: begin
        cmd.em_addr = 1'b1;
        state_next  = S_E_CHK;
      end
      S_E_CHK: begin
        // keep the column byte read steady while the output is held
        cmd.em_addr = 1'b1;
        if (sts.i_zero) begin
          cmd.run_start = 1'b1;
          state_next    = S_E_NEXT;
        end else if (sts.sym_eq && !sts.len_max) begin
          cmd.run_inc = 1'b1;
          state_next  = S_E_NEXT;
        end else if (!sts.out_busy) begin
          cmd.out_load  = 1'b1;
          cmd.run_start = 1'b1;
          state_next    = S_E_NEXT;
        end
      end
      S_E_NEXT: begin
        if (sts.i_last) state_next = S_E_LAST;
        else begin
          cmd.i_adv  = 1'b1;
          state_next = S_E_ORD;
        end
      end
      S_E_LAST: begin
        if (!sts.out_busy) begin
          cmd.out_load  = 1'b1;
          cmd.out_final = 1'b1;
          cmd.blk_done  = 1'b1;
          state_next    = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

endmodule

@@ hw/rtl/bwtr_dp.sv @@
// ----------------------------------------------------------------------------
// bwtr_dp
// Datapath: symbol store, order store, counters, rotation compare, run regs.
// ----------------------------------------------------------------------------
module bwtr_dp #(
  parameter int unsigned BLOCK_LEN = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [7:0]          symbol,
  input  logic                block_end,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          run_symbol,
  output logic [6:0]          run_length,
  output logic                run_final,
  input  bwtr_pkg::bwtr_cmd_t cmd,
  output bwtr_pkg::bwtr_sts_t sts
);
  import bwtr_pkg::*;

  localparam int unsigned IW = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
  localparam int unsigned CW = $clog2(BLOCK_LEN + 1);

  sym_t            store [BLOCK_LEN];
  logic [IW-1:0]   order [BLOCK_LEN];
  logic [CW-1:0]   count;
  logic [CW-1:0]   cm1;
  logic [IW-1:0]   last_idx;
  logic [IW-1:0]   a, b, k, pa, pb, rank, i;
  logic [IW-1:0]   ord_q, prev_idx, addr_a;
  sym_t            rd_a, rd_b, cur;
  run_len_t        len;
  key_t            ka, kb;

  assign cm1      = count - CW'(1);
  assign last_idx = cm1[IW-1:0];
  assign prev_idx = (ord_q == '0) ? last_idx : ord_q - IW'(1);
  assign addr_a   = cmd.em_addr ? prev_idx : pa;
  assign ka       = rank_of(rd_a);
  assign kb       = rank_of(rd_b);

  // memories: one write port, registered reads
  always_ff @(posedge clk) begin
    if (cmd.load_wr) store[count[IW-1:0]] <= symbol;
    rd_a <= store[addr_a];
    rd_b <= store[pb];
    if (cmd.ord_wr) order[rank] <= a;
    ord_q <= order[i];
  end

  // fill count
  always_ff @(posedge clk) begin
    if (rst || cmd.blk_done) count <= '0;
    else if (cmd.load_wr)    count <= count + CW'(1);
  end

  // sort counters
  always_ff @(posedge clk) begin
    if (cmd.a_clr) a <= '0;
    else if (cmd.a_adv) a <= a + IW'(1);
    if (cmd.b_init) begin
      b    <= '0;
      rank <= '0;
    end else begin
      if (cmd.b_adv)    b    <= b + IW'(1);
      if (cmd.rank_inc) rank <= rank + IW'(1);
    end
    if (cmd.step_init) begin
      k  <= '0;
      pa <= a;
      pb <= b;
    end else if (cmd.step_adv) begin
      k  <= k + IW'(1);
      pa <= (pa == last_idx) ? '0 : pa + IW'(1);
      pb <= (pb == last_idx) ? '0 : pb + IW'(1);
    end
  end

  // emission index and current run
  always_ff @(posedge clk) begin
    if (cmd.em_init) i <= '0;
    else if (cmd.i_adv) i <= i + IW'(1);
    if (cmd.run_start) begin
      cur <= rd_a;
      len <= run_len_t'(1);
    end else if (cmd.run_inc) begin
      len <= len + run_len_t'(1);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
    if (cmd.out_load) begin
      run_symbol <= cur;
      run_length <= len;
      run_final  <= cmd.out_final;
    end
  end

  always_comb begin
    sts.close    = block_end || (count == CW'(BLOCK_LEN - 1));
    sts.key_ne   = (ka != kb);
    sts.key_lt   = (kb < ka);
    sts.k_last   = (k == last_idx);
    sts.b_eq_a   = (b == a);
    sts.b_lt_a   = (b < a);
    sts.b_last   = (b == last_idx);
    sts.a_last   = (a == last_idx);
    sts.i_zero   = (i == '0);
    sts.i_last   = (i == last_idx);
    sts.sym_eq   = (rd_a == cur);
    sts.len_max  = (len == RUN_MAX);
    sts.out_busy = out_valid && !out_ready;
  end

`ifndef ASSERT_OFF
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(out_valid && !out_ready))
    else $error("output word overwritten while held");
  a_rank_range: assert property (@(posedge clk) disable iff (rst)
    cmd.ord_wr |-> (rank <= last_idx))
    else $error("rotation rank beyond block");
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    cmd.load_wr |-> (count < CW'(BLOCK_LEN)))
    else $error("symbol store overfilled");
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (len != '0))
    else $error("empty run emitted");
`endif

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Checks bwt_then_run_length_encode. Symbols are sent as blocks; a predictor
// sorts the rotations of each closed block under the byte collation and
// queues the run-length coded last column. Each run word on the output is
// compared, field by field, with the oldest queued run.
// ----------------------------------------------------------------------------
module testbench;
  import bwtr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BLOCK_LEN = 64;

  typedef struct {
    sym_t     sym;
    run_len_t len;
    logic     fin;
  } run_word_t;

  logic clk;
  logic rst;
  bwtr_sym_if text ();
  bwtr_run_if runs ();

  bwt_then_run_length_encode #(.BLOCK_LEN(BLOCK_LEN)) DUT (
    .clk  (clk),
    .rst  (rst),
    .text (text.sink),
    .runs (runs.source)
  );

  // Collation rank per byte value and the predictor's block buffer
  int unsigned collation_rank [256];
  sym_t        block_buf [BLOCK_LEN];
  int unsigned block_fill;
  run_word_t   runs_pending [$];
  int unsigned mismatch_count;
  int unsigned words_sent;
  bit          stall_on;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Run limit
  initial begin
    #60ms;
    $display("bwt_then_run_length_encode test failed");
    $finish;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Build the rank table: listed bytes by position, others after by value
  task automatic build_collation();
    byte unsigned alphabet [$];
    alphabet = '{8'hA1, 8'hBF, "!", "$", "'", "+", ",", ".", "-", ":", ";", "?",
                 "^", "_", "|", "[", "]", "(", ")"};
    for (int c = "A"; c <= "N"; c++) alphabet.push_back(8'(c));
    alphabet.push_back(8'hD1);
    for (int c = "O"; c <= "Z"; c++) alphabet.push_back(8'(c));
    for (int c = "a"; c <= "n"; c++) alphabet.push_back(8'(c));
    alphabet.push_back(8'hF1);
    for (int c = "o"; c <= "z"; c++) alphabet.push_back(8'(c));
    for (int b = 0; b < 256; b++) collation_rank[b] = 73 + b;
    for (int p = alphabet.size() - 1; p >= 0; p--) collation_rank[alphabet[p]] = p;
  endtask

  // True when rotation a sorts strictly after rotation b
  function automatic bit rotation_after(int unsigned a, int unsigned b, int unsigned n);
    int unsigned pa, pb, ka, kb;
    pa = a;
    pb = b;
    for (int k = 0; k < n; k++) begin
      ka = collation_rank[block_buf[pa]];
      kb = collation_rank[block_buf[pb]];
      if (ka != kb) return ka > kb;
      pa = (pa + 1 == n) ? 0 : pa + 1;
      pb = (pb + 1 == n) ? 0 : pb + 1;
    end
    return 1'b0;
  endfunction

  // Sort the rotations, take the last column and queue its runs
  task automatic encode_block();
    int unsigned order [BLOCK_LEN];
    sym_t        column [BLOCK_LEN];
    int unsigned n, j, v, i, len;
    run_word_t   rw;
    n = block_fill;
    for (int k = 0; k < n; k++) begin
      v = k;
      j = k;
      while (j > 0 && rotation_after(order[j-1], v, n)) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = v;
    end
    for (int k = 0; k < n; k++) column[k] = block_buf[(order[k] + n - 1) % n];
    i = 0;
    while (i < n) begin
      len = 1;
      while (i + len < n && column[i+len] == column[i] && len < 127) len++;
      rw.sym = column[i];
      rw.len = run_len_t'(len);
      rw.fin = (i + len >= n);
      runs_pending.push_back(rw);
      i += len;
    end
    block_fill = 0;
  endtask

  // Send one word, predicting on acceptance
  task automatic send_symbol(input sym_t s, input logic last);
    if (stall_on && $urandom_range(0, 3) == 0) begin
      text.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    text.valid     = 1'b1;
    text.symbol    = s;
    text.block_end = last;
    do @(posedge clk); while (!text.ready);
    block_buf[block_fill] = s;
    block_fill++;
    words_sent++;
    if (last || block_fill == BLOCK_LEN) encode_block();
    @(negedge clk);
  endtask

  // Hold off the sender until every queued run is out
  task automatic drain_runs();
    text.valid = 1'b0;
    while (runs_pending.size() != 0) @(negedge clk);
  endtask

  // Random byte, mostly from the listed alphabet region
  function automatic sym_t pick_symbol();
    case ($urandom_range(0, 3))
      0:       return sym_t'($urandom_range(0, 255));
      1:       return sym_t'($urandom_range("A", "D"));
      default: return sym_t'($urandom_range(8'h20, 8'h7F));
    endcase
  endfunction

  task automatic send_random_block(input int unsigned n);
    for (int k = 0; k < n; k++) send_symbol(pick_symbol(), k == n - 1);
  endtask

  // Receiver: random ready bursts
  initial begin
    runs.ready = 1'b0;
    forever begin
      if (stall_on && $urandom_range(0, 2) == 0) begin
        runs.ready = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end else begin
        runs.ready = 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
      end
    end
  end

  // Run checker
  always @(posedge clk) begin
    run_word_t want;
    if (!rst && runs.valid && runs.ready) begin
      if (runs_pending.size() == 0) begin
        report_mismatch($sformatf("unexpected run %h x%0d", runs.run_symbol,
                                  runs.run_length));
      end else begin
        want = runs_pending.pop_front();
        if (runs.run_symbol !== want.sym)
          report_mismatch($sformatf("run_symbol %h, want %h", runs.run_symbol, want.sym));
        if (runs.run_length !== want.len)
          report_mismatch($sformatf("run_length %0d, want %0d", runs.run_length, want.len));
        if (runs.run_final !== want.fin)
          report_mismatch($sformatf("run_final %b, want %b", runs.run_final, want.fin));
      end
    end
  end

  // Field extremes, listed and unlisted bytes, one-symbol blocks
  task automatic test_extremes();
    send_symbol(8'h00, 1'b1);
    send_symbol(8'hFF, 1'b1);
    send_symbol(8'hA1, 1'b0);
    send_symbol(8'hBF, 1'b0);
    send_symbol(8'hD1, 1'b0);
    send_symbol(8'hF1, 1'b0);
    send_symbol(8'h7F, 1'b0);
    send_symbol("z", 1'b0);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hFF, 1'b1);
    drain_runs();
  endtask

  // Periodic blocks with equal rotations, and one long run
  task automatic test_periodic();
    for (int k = 0; k < 6; k++) send_symbol(k[0] ? "b" : "a", k == 5);
    for (int k = 0; k < 5; k++) send_symbol("Q", k == 4);
    drain_runs();
  endtask

  // Full store closes the block with block_end low, then with it high
  task automatic test_full_store();
    for (int k = 0; k < BLOCK_LEN; k++) send_symbol(pick_symbol(), 1'b0);
    drain_runs();
    send_random_block(BLOCK_LEN);
    drain_runs();
  endtask

  // Mostly short random blocks
  task automatic test_random_blocks(input int unsigned count);
    int unsigned start;
    start = words_sent;
    while (words_sent - start < count) begin
      send_random_block($urandom_range(1, 10));
      if ($urandom_range(0, 5) == 0) drain_runs();
    end
  endtask

  initial begin
    stall_on       = 1'b1;
    mismatch_count = 0;
    words_sent     = 0;
    block_fill     = 0;
    text.valid     = 1'b0;
    text.symbol    = '0;
    text.block_end = 1'b0;
    build_collation();
    rst = 1'b1;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_extremes();
    test_periodic();
    test_full_store();
    test_random_blocks(8);
    stall_on = 1'b0;
    test_random_blocks(5);

    text.valid = 1'b0;
    while (runs_pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (mismatch_count == 0 && block_fill == 0) begin
      $display("bwt_then_run_length_encode test passed");
    end else begin
      $display("bwt_then_run_length_encode test failed");
    end
    $finish;
  end

endmodule
